### rtl/lbt_pkg.sv
// ----------------------------------------------------------------------------
// lbt_pkg
// Shared types and constants of the line blob tracker.
// ----------------------------------------------------------------------------
package lbt_pkg;

  // configuration register index
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AREA_MIN = 3'd0,
    CFG_AREA_MAX = 3'd1,
    CFG_MAX_MOVE = 3'd2,
    CFG_CENTER_X = 3'd3,
    CFG_CENTER_Y = 3'd4
  } lbt_cfg_idx_e;

  // item command
  typedef enum logic {
    CMD_BLOB = 1'b0,
    CMD_EOF  = 1'b1
  } lbt_cmd_e;

  // register reset values
  localparam int AREA_MIN_RST = 100;
  localparam int AREA_MAX_RST = 5000;
  localparam int MAX_MOVE_RST = 80;
  localparam int CENTER_X_RST = 320;
  localparam int CENTER_Y_RST = 45;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } lbt_q_stat_t;

endpackage

### rtl/lbt_if.sv
// ----------------------------------------------------------------------------
// lbt_if
// Valid/ready channels: blob records in, tracked line results out.
// ----------------------------------------------------------------------------
interface lbt_in_if #(
  parameter int COORD_BITS = 11,
  parameter int AREA_BITS  = 20
);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [AREA_BITS-1:0]  area;
  logic [COORD_BITS-1:0] box_left;
  logic [COORD_BITS-1:0] box_top;
  logic [COORD_BITS-1:0] box_width;
  logic [COORD_BITS-1:0] box_height;

  modport source (
    output valid, cmd, area, box_left, box_top, box_width, box_height,
    input  ready
  );
  modport sink (
    input  valid, cmd, area, box_left, box_top, box_width, box_height,
    output ready
  );
endinterface

interface lbt_out_if #(
  parameter int COORD_BITS = 11
);
  logic                         valid;
  logic                         ready;
  logic                         line_found;
  logic signed [COORD_BITS:0]   line_error;
  logic        [COORD_BITS-1:0] line_x;
  logic        [COORD_BITS-1:0] line_y;

  modport source (
    output valid, line_found, line_error, line_x, line_y,
    input  ready
  );
  modport sink (
    input  valid, line_found, line_error, line_x, line_y,
    output ready
  );
endinterface

### rtl/lbt_queue.sv
// ----------------------------------------------------------------------------
// lbt_queue
// Small register FIFO between the classifier and the tracking engine.
// ----------------------------------------------------------------------------
module lbt_queue import lbt_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output lbt_q_stat_t      stat_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o      = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!stat_o.full || pop_i))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("queue pop while empty");

endmodule

### rtl/lbt_front.sv
// ----------------------------------------------------------------------------
// lbt_front
// Accepts blob beats, filters by area and forms the box centre.
// ----------------------------------------------------------------------------
module lbt_front import lbt_pkg::*; #(
  parameter int COORD_BITS = 11,
  parameter int AREA_BITS  = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  lbt_in_if.sink                  blob_i,
  input  logic [AREA_BITS-1:0]    area_min_i,
  input  logic [AREA_BITS-1:0]    area_max_i,
  input  lbt_q_stat_t             q_stat_i,
  output logic                    push_o,
  output logic [2*COORD_BITS:0]   entry_o
);

  logic                  accept;
  logic                  area_ok;
  logic [COORD_BITS:0]   sum_x, sum_y;
  logic [COORD_BITS-1:0] cx, cy;

  assign blob_i.ready = !q_stat_i.full;
  assign accept       = blob_i.valid && blob_i.ready;

  assign area_ok = (blob_i.area > area_min_i) && (blob_i.area < area_max_i);

  assign sum_x = {1'b0, blob_i.box_left} + {2'b0, blob_i.box_width[COORD_BITS-1:1]};
  assign sum_y = {1'b0, blob_i.box_top}  + {2'b0, blob_i.box_height[COORD_BITS-1:1]};
  // saturate past the coordinate range
  assign cx = sum_x[COORD_BITS] ? '1 : sum_x[COORD_BITS-1:0];
  assign cy = sum_y[COORD_BITS] ? '1 : sum_y[COORD_BITS-1:0];

  // rejected blobs are dropped here, they never touch the tracker state
  assign push_o  = accept && ((blob_i.cmd == CMD_EOF) || area_ok);
  assign entry_o = {blob_i.cmd, cx, cy};

  a_eof_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && blob_i.cmd == CMD_EOF) |-> push_o)
    else $error("end-of-frame beat not queued");

endmodule

### rtl/lbt_back.sv
// ----------------------------------------------------------------------------
// lbt_back
// Nearest-candidate search, track update and result register.
// ----------------------------------------------------------------------------
module lbt_back import lbt_pkg::*; #(
  parameter int COORD_BITS = 11
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [2*COORD_BITS:0]   entry_i,
  input  lbt_q_stat_t             q_stat_i,
  output logic                    pop_o,
  input  logic [COORD_BITS-1:0]   max_move_i,
  input  logic [COORD_BITS-1:0]   center_x_i,
  input  logic [COORD_BITS-1:0]   center_y_i,
  lbt_out_if.source               line_o
);

  localparam int SQ_W = 2 * COORD_BITS;
  localparam int D_W  = SQ_W + 1;

  logic                    e_cmd;
  logic [COORD_BITS-1:0]   e_x, e_y;
  logic                    is_eof, out_free;

  logic                    locked_q, locked_d;
  logic [COORD_BITS-1:0]   track_x_q, track_x_d, track_y_q, track_y_d;
  logic signed [COORD_BITS:0] held_err_q, held_err_d;
  logic                    best_found_q, best_found_d;
  logic [D_W-1:0]          best_d_q, best_d_d;
  logic [COORD_BITS-1:0]   best_x_q, best_x_d, best_y_q, best_y_d;
  logic [SQ_W-1:0]         mm_sq_q;

  logic                    out_valid_q, out_valid_d;
  logic                    found_q;
  logic signed [COORD_BITS:0] err_q;
  logic [COORD_BITS-1:0]   lx_q, ly_q;

  logic [COORD_BITS-1:0]   rx, ry, dx, dy;
  logic [D_W-1:0]          cand_dsq;
  logic                    take;

  assign {e_cmd, e_x, e_y} = entry_i;
  assign is_eof   = (e_cmd == CMD_EOF);
  assign out_free = !out_valid_q || line_o.ready;
  // blobs drain every cycle; an end of frame waits for a free result slot
  assign pop_o    = !q_stat_i.empty && (!is_eof || out_free);

  assign rx       = locked_q ? track_x_q : center_x_i;
  assign ry       = locked_q ? track_y_q : center_y_i;
  assign dx       = (e_x > rx) ? (e_x - rx) : (rx - e_x);
  assign dy       = (e_y > ry) ? (e_y - ry) : (ry - e_y);
  assign cand_dsq = D_W'(SQ_W'(dx) * SQ_W'(dx)) + D_W'(SQ_W'(dy) * SQ_W'(dy));
  assign take     = (!best_found_q || (cand_dsq < best_d_q)) &&
                    !(locked_q && (cand_dsq > D_W'(mm_sq_q)));

  always_comb begin
    locked_d     = locked_q;
    track_x_d    = track_x_q;
    track_y_d    = track_y_q;
    held_err_d   = held_err_q;
    best_found_d = best_found_q;
    best_d_d     = best_d_q;
    best_x_d     = best_x_q;
    best_y_d     = best_y_q;
    out_valid_d  = out_valid_q && !line_o.ready;
    if (pop_o && !is_eof && take) begin
      best_found_d = 1'b1;
      best_d_d     = cand_dsq;
      best_x_d     = e_x;
      best_y_d     = e_y;
    end
    if (pop_o && is_eof) begin
      if (best_found_q) begin
        track_x_d = best_x_q;
        track_y_d = best_y_q;
        locked_d  = 1'b1;
      end
      if (locked_d) begin
        held_err_d = $signed({1'b0, center_x_i}) - $signed({1'b0, track_x_d});
      end
      best_found_d = 1'b0;
      best_d_d     = '0;
      best_x_d     = '0;
      best_y_d     = '0;
      out_valid_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q     <= 1'b0;
      track_x_q    <= '0;
      track_y_q    <= '0;
      held_err_q   <= '0;
      best_found_q <= 1'b0;
      best_d_q     <= '0;
      best_x_q     <= '0;
      best_y_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      locked_q     <= locked_d;
      track_x_q    <= track_x_d;
      track_y_q    <= track_y_d;
      held_err_q   <= held_err_d;
      best_found_q <= best_found_d;
      best_d_q     <= best_d_d;
      best_x_q     <= best_x_d;
      best_y_q     <= best_y_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // move limit squared, registered from the config register
  always_ff @(posedge clk_i) begin
    mm_sq_q <= SQ_W'(max_move_i) * SQ_W'(max_move_i);
    if (pop_o && is_eof) begin
      found_q <= locked_d;
      err_q   <= held_err_d;
      lx_q    <= track_x_d;
      ly_q    <= track_y_d;
    end
  end

  assign line_o.valid      = out_valid_q;
  assign line_o.line_found = found_q;
  assign line_o.line_error = err_q;
  assign line_o.line_x     = lx_q;
  assign line_o.line_y     = ly_q;

  a_lock_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    locked_q |=> locked_q)
    else $error("lock dropped");

  a_best_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && is_eof) |=> (!best_found_q && out_valid_q))
    else $error("frame end did not clear search or post result");

  a_found_matches_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (found_q == locked_q))
    else $error("result found flag disagrees with lock");

endmodule

### rtl/line_blob_tracker_unit.sv
// ----------------------------------------------------------------------------
// line_blob_tracker_unit
// Nearest-neighbor line tracker over per-frame blob statistics.
// ----------------------------------------------------------------------------
// Blob beats (cmd = blob) and one end-of-frame beat per frame stream in on
// blob_i; one result beat leaves on line_o per end of frame. The block takes
// one beat per clock while blob_i.ready is high: the front end filters the
// area window and forms the box centre in the accept cycle, a two-entry queue
// hands it to the back end, which compares the squared distance against the
// running best. An end of frame passes through the queue and the result
// register to line_o. Only a result that is not taken stalls the back end,
// and the queue then holds the waiting end of frame plus one more beat
// before blob_i.ready drops. Config writes (cfg_we_i) must go in only while
// the block is idle (not enforced); the squared move limit is registered.
module line_blob_tracker_unit import lbt_pkg::*; #(
  parameter int COORD_BITS = 11,
  parameter int AREA_BITS  = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [((AREA_BITS > COORD_BITS) ? AREA_BITS : COORD_BITS)-1:0] cfg_data_i,
  lbt_in_if.sink                 blob_i,
  lbt_out_if.source              line_o
);

  localparam int ENTRY_W = 2 * COORD_BITS + 1;

  logic [AREA_BITS-1:0]  area_min_q, area_max_q;
  logic [COORD_BITS-1:0] max_move_q, center_x_q, center_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_min_q <= AREA_BITS'(AREA_MIN_RST);
      area_max_q <= AREA_BITS'(AREA_MAX_RST);
      max_move_q <= COORD_BITS'(MAX_MOVE_RST);
      center_x_q <= COORD_BITS'(CENTER_X_RST);
      center_y_q <= COORD_BITS'(CENTER_Y_RST);
    end else if (cfg_we_i) begin
      unique case (lbt_cfg_idx_e'(cfg_idx_i))
        CFG_AREA_MIN: area_min_q <= cfg_data_i[AREA_BITS-1:0];
        CFG_AREA_MAX: area_max_q <= cfg_data_i[AREA_BITS-1:0];
        CFG_MAX_MOVE: max_move_q <= cfg_data_i[COORD_BITS-1:0];
        CFG_CENTER_X: center_x_q <= cfg_data_i[COORD_BITS-1:0];
        CFG_CENTER_Y: center_y_q <= cfg_data_i[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic               push, pop;
  logic [ENTRY_W-1:0] wentry, rentry;
  lbt_q_stat_t        q_stat;

  lbt_front #(
    .COORD_BITS (COORD_BITS),
    .AREA_BITS  (AREA_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .blob_i     (blob_i),
    .area_min_i (area_min_q),
    .area_max_i (area_max_q),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .entry_o    (wentry)
  );

  lbt_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wentry),
    .pop_i   (pop),
    .rdata_o (rentry),
    .stat_o  (q_stat)
  );

  lbt_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (rentry),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .max_move_i (max_move_q),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .line_o     (line_o)
  );

endmodule

### tb/sv/line_blob_tracker_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_blob_tracker_unit_tb
// Streams frames of blob beats and end-of-frame beats into the tracker while
// a scoreboard predicts the line centre and error, compares every result beat
// and varies the tracker registers between idle phases.
// ----------------------------------------------------------------------------
module line_blob_tracker_unit_tb;
  import lbt_pkg::*;

  localparam int CW           = 11;
  localparam int AW           = 20;
  localparam int DW           = (AW > CW) ? AW : CW;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RAND_ITEMS   = 950;
  localparam int NUM_PHASES   = 7;

  typedef struct packed {
    lbt_cmd_e        cmd;
    logic [AW-1:0]   area;
    logic [CW-1:0]   left;
    logic [CW-1:0]   top;
    logic [CW-1:0]   width;
    logic [CW-1:0]   height;
  } blob_beat_t;

  typedef struct packed {
    logic              found;
    logic signed [CW:0] err;
    logic [CW-1:0]     x;
    logic [CW-1:0]     y;
  } line_beat_t;

  typedef struct packed {
    logic [AW-1:0] amin;
    logic [AW-1:0] amax;
    logic [CW-1:0] move;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
  } track_cfg_t;

  class line_track_sb;
    logic [AW-1:0]      amin, amax;
    logic [CW-1:0]      move, cx, cy;
    bit                 locked;
    logic [CW-1:0]      track_x, track_y;
    logic signed [CW:0] held_err;
    bit                 have_best;
    logic [2*CW:0]      best_dsq;
    logic [CW-1:0]      best_x, best_y;
    line_beat_t         frame_q[$];
    int                 n_err;

    function new();
      amin      = AW'(AREA_MIN_RST);
      amax      = AW'(AREA_MAX_RST);
      move      = CW'(MAX_MOVE_RST);
      cx        = CW'(CENTER_X_RST);
      cy        = CW'(CENTER_Y_RST);
      locked    = 1'b0;
      track_x   = '0;
      track_y   = '0;
      held_err  = '0;
      have_best = 1'b0;
      best_dsq  = '0;
      best_x    = '0;
      best_y    = '0;
      n_err     = 0;
    endfunction

    function void set_reg(lbt_cfg_idx_e idx, logic [DW-1:0] v);
      case (idx)
        CFG_AREA_MIN: amin = v[AW-1:0];
        CFG_AREA_MAX: amax = v[AW-1:0];
        CFG_MAX_MOVE: move = v[CW-1:0];
        CFG_CENTER_X: cx   = v[CW-1:0];
        CFG_CENTER_Y: cy   = v[CW-1:0];
        default: ;
      endcase
    endfunction

    // box start plus half its size, clamped to the coordinate range
    function logic [CW-1:0] box_mid(logic [CW-1:0] start, logic [CW-1:0] size);
      logic [CW:0] s;
      s = {1'b0, start} + {2'b0, size[CW-1:1]};
      return s[CW] ? '1 : s[CW-1:0];
    endfunction

    function int pending();
      return frame_q.size();
    endfunction

    function void note_item(blob_beat_t b);
      logic [CW-1:0] px, py, ax, ay;
      logic [2*CW:0] dx, dy, dsq, lim, mv;
      bit            take;
      line_beat_t    res;
      if (b.cmd == CMD_BLOB) begin
        if (!(b.area > amin && b.area < amax)) return;
        px   = box_mid(b.left, b.width);
        py   = box_mid(b.top, b.height);
        ax   = locked ? track_x : cx;
        ay   = locked ? track_y : cy;
        dx   = (px > ax) ? px - ax : ax - px;
        dy   = (py > ay) ? py - ay : ay - py;
        dsq  = dx * dx + dy * dy;
        mv   = {{(CW+1){1'b0}}, move};
        lim  = mv * mv;
        take = !have_best || dsq < best_dsq;
        if (locked && dsq > lim) take = 1'b0;
        if (take) begin
          have_best = 1'b1;
          best_dsq  = dsq;
          best_x    = px;
          best_y    = py;
        end
      end else begin
        if (have_best) begin
          track_x = best_x;
          track_y = best_y;
          locked  = 1'b1;
        end
        if (locked) held_err = $signed({1'b0, cx}) - $signed({1'b0, track_x});
        res.found = locked;
        res.err   = held_err;
        res.x     = track_x;
        res.y     = track_y;
        frame_q   = {frame_q, res};
        have_best = 1'b0;
        best_dsq  = '0;
        best_x    = '0;
        best_y    = '0;
      end
    endfunction

    task report(string what);
      if (n_err < 40) $display("ERROR @%0t: %s", $time, what);
      n_err++;
    endtask

    task check_result(line_beat_t got);
      line_beat_t want;
      if (frame_q.size() == 0) begin
        report($sformatf("unexpected result beat x=%0d y=%0d", got.x, got.y));
        return;
      end
      want = frame_q.pop_front();
      if (got.found !== want.found)
        report($sformatf("line_found %0b, want %0b", got.found, want.found));
      if (got.err !== want.err)
        report($sformatf("line_error %0d, want %0d", got.err, want.err));
      if (got.x !== want.x)
        report($sformatf("line_x %0d, want %0d", got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("line_y %0d, want %0d", got.y, want.y));
    endtask
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [2:0]    cfg_idx_i;
  logic [DW-1:0] cfg_data_i;
  bit            quiet;
  int            idle_cycles;
  line_track_sb  sb;

  lbt_in_if  #(.COORD_BITS(CW), .AREA_BITS(AW)) blob_bus ();
  lbt_out_if #(.COORD_BITS(CW))                 line_bus ();

  line_blob_tracker_unit #(
    .COORD_BITS(CW),
    .AREA_BITS (AW)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .blob_i    (blob_bus),
    .line_o    (line_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function int draw_wait();
    return quiet ? 0 : $urandom_range(0, 5);
  endfunction

  function logic [CW-1:0] clip(int v);
    if (v < 0) return '0;
    if (v > (1 << CW) - 1) return '1;
    return v[CW-1:0];
  endfunction

  function blob_beat_t blob(int area, int l, int t, int w, int h);
    blob_beat_t b;
    b.cmd    = CMD_BLOB;
    b.area   = area[AW-1:0];
    b.left   = l[CW-1:0];
    b.top    = t[CW-1:0];
    b.width  = w[CW-1:0];
    b.height = h[CW-1:0];
    return b;
  endfunction

  function blob_beat_t frame_end();
    blob_beat_t b;
    b.cmd    = CMD_EOF;
    b.area   = AW'($urandom);
    b.left   = CW'($urandom);
    b.top    = CW'($urandom);
    b.width  = CW'($urandom);
    b.height = CW'($urandom);
    return b;
  endfunction

  // mostly blobs around the point the tracker measures from, some noise
  function blob_beat_t random_blob();
    blob_beat_t b;
    int         kind, spread, ax, ay, w, h, ox, oy;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      b = frame_end();
      b.cmd = CMD_BLOB;
      return b;
    end
    ax     = int'(sb.locked ? sb.track_x : sb.cx);
    ay     = int'(sb.locked ? sb.track_y : sb.cy);
    spread = sb.move + sb.move / 4 + 3;
    if (kind == 2) begin
      w  = 2 * $urandom_range(0, 20);
      h  = 2 * $urandom_range(0, 20);
      ox = 0;
      oy = 0;
    end else begin
      w  = $urandom_range(0, 40);
      h  = $urandom_range(0, 40);
      ox = $urandom_range(0, 2 * spread) - spread;
      oy = $urandom_range(0, 2 * spread) - spread;
    end
    b.cmd    = CMD_BLOB;
    b.left   = clip(ax + ox - w / 2);
    b.top    = clip(ay + oy - h / 2);
    b.width  = w[CW-1:0];
    b.height = h[CW-1:0];
    if ($urandom_range(0, 5) != 0 && sb.amax > sb.amin + 1)
      b.area = AW'($urandom_range(int'(sb.amin) + 1, int'(sb.amax) - 1));
    else
      case ($urandom_range(0, 2))
        0: b.area = sb.amin;
        1: b.area = sb.amax;
        default: b.area = AW'($urandom);
      endcase
    return b;
  endfunction

  function track_cfg_t phase_setting(int p);
    track_cfg_t s;
    case (p)
      0: s = '{AW'(AREA_MIN_RST), AW'(AREA_MAX_RST), CW'(MAX_MOVE_RST),
               CW'(CENTER_X_RST), CW'(CENTER_Y_RST)};
      1: s = '{'0, '1, '1, '1, '1};
      2: s = '{'1, '0, '0, '0, '0};
      3: s = '{AW'(50), AW'(60000), '0, CW'(1024), CW'(512)};
      default: begin
        s.amin = AW'($urandom_range(0, 3000));
        s.amax = s.amin + AW'($urandom_range(0, 20000));
        s.move = CW'($urandom_range(0, 400));
        s.cx   = CW'($urandom);
        s.cy   = CW'($urandom);
      end
    endcase
    return s;
  endfunction

  task send_item(blob_beat_t b);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      blob_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    blob_bus.valid      <= 1'b1;
    blob_bus.cmd        <= b.cmd;
    blob_bus.area       <= b.area;
    blob_bus.box_left   <= b.left;
    blob_bus.box_top    <= b.top;
    blob_bus.box_width  <= b.width;
    blob_bus.box_height <= b.height;
    do @(posedge clk_i); while (!blob_bus.ready);
  endtask

  // sender holds off until every pending frame result is back and the
  // back end has flushed any blob still in flight
  task wait_drained();
    blob_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task apply_setting(track_cfg_t s);
    logic [DW-1:0] v [5];
    v[0] = s.amin;
    v[1] = s.amax;
    v[2] = DW'(s.move);
    v[3] = DW'(s.cx);
    v[4] = DW'(s.cy);
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= lbt_cfg_idx_e'(i);
      cfg_data_i <= v[i];
      @(posedge clk_i);
      sb.set_reg(lbt_cfg_idx_e'(i), v[i]);
    end
    cfg_we_i <= 1'b0;
    // let the registered move limit settle
    @(posedge clk_i);
  endtask

  // beat monitor: inputs first so a result never overtakes its frame end
  always @(posedge clk_i) begin
    blob_beat_t b;
    line_beat_t r;
    if (rst_ni) begin
      if (blob_bus.valid && blob_bus.ready) begin
        b.cmd    = lbt_cmd_e'(blob_bus.cmd);
        b.area   = blob_bus.area;
        b.left   = blob_bus.box_left;
        b.top    = blob_bus.box_top;
        b.width  = blob_bus.box_width;
        b.height = blob_bus.box_height;
        sb.note_item(b);
      end
      if (line_bus.valid && line_bus.ready) begin
        r.found = line_bus.line_found;
        r.err   = line_bus.line_error;
        r.x     = line_bus.line_x;
        r.y     = line_bus.line_y;
        sb.check_result(r);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((blob_bus.valid && blob_bus.ready) || (line_bus.valid && line_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        sb.report("timeout: no beat moved");
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    line_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        line_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      line_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!line_bus.valid);
    end
  end

  initial begin
    int sent, target, nb;
    sb                  = new();
    idle_cycles         = 0;
    quiet               = 1'b0;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CFG_AREA_MIN;
    cfg_data_i          <= '0;
    blob_bus.valid      <= 1'b0;
    blob_bus.cmd        <= CMD_BLOB;
    blob_bus.area       <= '0;
    blob_bus.box_left   <= '0;
    blob_bus.box_top    <= '0;
    blob_bus.box_width  <= '0;
    blob_bus.box_height <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames at the reset register values
    send_item(frame_end());                          // never locked
    send_item(blob(0, 0, 0, 0, 0));                  // area below window
    send_item(blob(100, 310, 35, 20, 20));           // area equal to min
    send_item(blob(5000, 310, 35, 20, 20));          // area equal to max
    send_item(blob(1048575, 2047, 2047, 2047, 2047));
    send_item(frame_end());
    send_item(blob(101, 300, 40, 20, 10));           // (310,45), squared dist 100
    send_item(blob(4999, 320, 45, 20, 0));           // (330,45) tie, first kept
    send_item(blob(2000, 2047, 2047, 2047, 2047));   // saturated centre
    send_item(frame_end());                          // lock on (310,45)
    send_item(blob(500, 390, 45, 0, 0));             // exactly at move limit
    send_item(blob(500, 229, 45, 1, 1));             // one past move limit
    send_item(frame_end());
    send_item(frame_end());                          // no candidate, hold track
    send_item(blob(300, 380, 40, 21, 11));           // distance zero
    send_item(blob(300, 395, 45, 0, 0));
    send_item(blob(300, 1, 2046, 2046, 1));
    send_item(frame_end());
    quiet = 1'b1;
    send_item(blob(4000, 385, 42, 4, 2));
    send_item(blob(4000, 0, 0, 2047, 2047));
    send_item(frame_end());
    quiet = 1'b0;

    target = RAND_ITEMS / NUM_PHASES;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      apply_setting(phase_setting(p));
      sent = 0;
      while (sent < target) begin
        quiet = ($urandom_range(0, 4) == 0);
        nb = $urandom_range(0, 6);
        repeat (nb) send_item(random_blob());
        send_item(frame_end());
        sent += nb + 1;
      end
      quiet = 1'b0;
    end

    wait_drained();
    if (sb.n_err == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/lbt_pkg.sv
rtl/lbt_if.sv
rtl/lbt_queue.sv
rtl/lbt_front.sv
rtl/lbt_back.sv
rtl/line_blob_tracker_unit.sv
tb/sv/line_blob_tracker_unit_tb.sv
